### rtl/ipv6_text_address_parser_core_defines.svh
// ----------------------------------------------------------------------------
// IPv6 text address parser assertion macros
// Concurrent check macros, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef IPV6_TEXT_ADDRESS_PARSER_CORE_DEFINES_SVH
`define IPV6_TEXT_ADDRESS_PARSER_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication check
`define IPV6P_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication check
`define IPV6P_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IPV6P_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define IPV6P_ASSERT_NXT(name, clk, rst, ante, cons, msg)
`endif

`endif

### rtl/ipv6p_pkg.sv
// ----------------------------------------------------------------------------
// IPv6 text address parser package
// Shared widths, character codes and limits.
// ----------------------------------------------------------------------------
package ipv6p_pkg;

  localparam int NUM_GROUPS  = 8;
  localparam int NUM_OCTETS  = 4;
  localparam int GROUP_IDX_W = 3;

  typedef logic [7:0]  char_t;
  typedef logic [15:0] group_t;
  typedef logic [8:0]  octet_t;

  localparam char_t CHAR_COLON = 8'h3a;
  localparam char_t CHAR_DOT   = 8'h2e;
  localparam char_t CHAR_ZERO  = 8'h30;
  localparam char_t CHAR_NINE  = 8'h39;
  localparam char_t CHAR_LC_A  = 8'h61;
  localparam char_t CHAR_LC_F  = 8'h66;
  localparam char_t CHAR_UC_A  = 8'h41;
  localparam char_t CHAR_UC_F  = 8'h46;

  localparam logic [2:0] MAX_DIGITS  = 3'd4;
  localparam logic [2:0] OVER_DIGITS = 3'd5;
  localparam logic [3:0] GROUPS_FULL = 4'd8;
  localparam logic [2:0] OCTET_LAST  = 3'd3;
  localparam logic [2:0] OCTET_PAST  = 3'd4;
  localparam octet_t     OCTET_SAT   = 9'd256;
  localparam group_t     MAPPED_MARK = 16'hffff;

endpackage

### rtl/ipv6p_char_if.sv
// ----------------------------------------------------------------------------
// IPv6 parser character channel
// One text character per word, with a last-character flag.
// ----------------------------------------------------------------------------
interface ipv6p_char_if import ipv6p_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t char_code;
  logic  is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

### rtl/ipv6p_addr_if.sv
// ----------------------------------------------------------------------------
// IPv6 parser address channel
// One parsed address per word: flags and eight 16-bit groups.
// ----------------------------------------------------------------------------
interface ipv6p_addr_if import ipv6p_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   addr_valid;
  logic   from_ipv4;
  group_t group_0;
  group_t group_1;
  group_t group_2;
  group_t group_3;
  group_t group_4;
  group_t group_5;
  group_t group_6;
  group_t group_7;

  modport source (output valid, output addr_valid, output from_ipv4,
                  output group_0, output group_1, output group_2, output group_3,
                  output group_4, output group_5, output group_6, output group_7,
                  input ready);
  modport sink   (input valid, input addr_valid, input from_ipv4,
                  input group_0, input group_1, input group_2, input group_3,
                  input group_4, input group_5, input group_6, input group_7,
                  output ready);
endinterface

### rtl/ipv6_text_address_parser_core.sv
// ----------------------------------------------------------------------------
// IPv6 text address parser core: the last accepted character sets text_done and the
// address word enters the output register once it is free. Throughput one character
// per cycle, set by the per-character state update, unless a finished text waits to leave.
// Synchronous active-high reset clears the parse control state and the output valid.
// ----------------------------------------------------------------------------
`include "ipv6_text_address_parser_core_defines.svh"

module ipv6_text_address_parser_core import ipv6p_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ipv6p_char_if.sink   chars,
  ipv6p_addr_if.source addr
);

  // Parse state
  group_t     head [NUM_GROUPS];
  group_t     tail [NUM_GROUPS];
  logic [3:0] groups_done;
  logic [3:0] gap_position;
  logic       gap_seen;
  logic [1:0] colon_run;
  logic [2:0] digit_count;
  group_t     group_accum;
  logic [1:0] chars_seen;
  logic       starts_with_colon;
  logic       v6_error;
  octet_t     octet_values [NUM_OCTETS];
  logic [2:0] octet_index;
  logic       octet_has_digit;
  logic       v4_possible;
  logic       text_done;

  // Base state: cleared when the previous text is being handed off
  logic [3:0] b_groups_done;
  logic [3:0] b_gap_position;
  logic       b_gap_seen;
  logic [1:0] b_colon_run;
  logic [2:0] b_digit_count;
  group_t     b_group_accum;
  logic [1:0] b_chars_seen;
  logic       b_starts_with_colon;
  logic       b_v6_error;
  octet_t     b_octet_values [NUM_OCTETS];
  logic [2:0] b_octet_index;
  logic       b_octet_has_digit;
  logic       b_v4_possible;

  // Next state
  logic [3:0] groups_done_next;
  logic [3:0] gap_position_next;
  logic       gap_seen_next;
  logic [1:0] colon_run_next;
  logic [2:0] digit_count_next;
  group_t     group_accum_next;
  logic [1:0] chars_seen_next;
  logic       starts_with_colon_next;
  logic       v6_error_next;
  octet_t     octet_values_next [NUM_OCTETS];
  logic [2:0] octet_index_next;
  logic       octet_has_digit_next;
  logic       v4_possible_next;

  logic       push_req;
  group_t     push_val;
  logic       wr_head;
  logic       wr_tail;

  logic       in_acc;
  logic       can_out;
  logic       done_go;

  logic       is_colon;
  logic       is_dot;
  logic       is_dec;
  logic       hex_ok;
  logic [3:0] hex_val;
  logic [12:0] octet_prod [NUM_OCTETS];

  logic       v4_take;
  logic       v4_ok;
  logic       v6_ok;
  logic       res_valid;
  group_t     res_group [NUM_GROUPS];

  // Handshake: a finished text leaves when the output register is free
  assign can_out     = !addr.valid || addr.ready;
  assign done_go     = text_done && can_out;
  assign chars.ready = !text_done || can_out;
  assign in_acc      = chars.valid && chars.ready;

  // Character classes
  always_comb begin
    is_colon = (chars.char_code == CHAR_COLON);
    is_dot   = (chars.char_code == CHAR_DOT);
    is_dec   = (chars.char_code >= CHAR_ZERO) && (chars.char_code <= CHAR_NINE);
    hex_ok   = 1'b0;
    hex_val  = chars.char_code[3:0];
    if (is_dec) begin
      hex_ok = 1'b1;
    end else if (((chars.char_code >= CHAR_LC_A) && (chars.char_code <= CHAR_LC_F)) ||
                 ((chars.char_code >= CHAR_UC_A) && (chars.char_code <= CHAR_UC_F))) begin
      hex_ok  = 1'b1;
      hex_val = chars.char_code[3:0] + 4'd9;
    end
  end

  // Start a new text from cleared state while the previous one drains
  always_comb begin
    b_groups_done       = text_done ? '0 : groups_done;
    b_gap_position      = text_done ? '0 : gap_position;
    b_gap_seen          = text_done ? 1'b0 : gap_seen;
    b_colon_run         = text_done ? '0 : colon_run;
    b_digit_count       = text_done ? '0 : digit_count;
    b_group_accum       = text_done ? '0 : group_accum;
    b_chars_seen        = text_done ? '0 : chars_seen;
    b_starts_with_colon = text_done ? 1'b0 : starts_with_colon;
    b_v6_error          = text_done ? 1'b0 : v6_error;
    b_octet_index       = text_done ? '0 : octet_index;
    b_octet_has_digit   = text_done ? 1'b0 : octet_has_digit;
    b_v4_possible       = text_done ? 1'b1 : v4_possible;
    for (int k = 0; k < NUM_OCTETS; k++) begin
      b_octet_values[k] = text_done ? '0 : octet_values[k];
    end
  end

  // IPv6 group tracking for one character
  always_comb begin
    groups_done_next       = b_groups_done;
    gap_position_next      = b_gap_position;
    gap_seen_next          = b_gap_seen;
    colon_run_next         = b_colon_run;
    digit_count_next       = b_digit_count;
    group_accum_next       = b_group_accum;
    starts_with_colon_next = b_starts_with_colon;
    v6_error_next          = b_v6_error;
    push_req               = 1'b0;
    wr_head                = 1'b0;
    wr_tail                = 1'b0;

    if ((b_chars_seen == 2'd0) && is_colon) starts_with_colon_next = 1'b1;
    if ((b_chars_seen == 2'd1) && b_starts_with_colon && !is_colon) v6_error_next = 1'b1;

    if (is_colon) begin
      if (b_colon_run >= 2'd2) begin
        v6_error_next  = 1'b1;
        colon_run_next = 2'd3;
      end else if (b_colon_run == 2'd1) begin
        colon_run_next    = 2'd2;
        if (b_gap_seen) v6_error_next = 1'b1;
        gap_seen_next     = 1'b1;
        gap_position_next = b_groups_done;
      end else begin
        colon_run_next = 2'd1;
        push_req       = (b_digit_count != 3'd0);
      end
      digit_count_next = '0;
      group_accum_next = '0;
    end else if (hex_ok) begin
      colon_run_next = '0;
      if (b_digit_count >= MAX_DIGITS) begin
        v6_error_next    = 1'b1;
        digit_count_next = OVER_DIGITS;
      end else begin
        digit_count_next = b_digit_count + 3'd1;
      end
      group_accum_next = {b_group_accum[11:0], hex_val};
    end else begin
      v6_error_next = 1'b1;
    end

    // Close the open group and reject a trailing single colon
    if (chars.is_last) begin
      if (digit_count_next != 3'd0) push_req = 1'b1;
      if (is_colon && (colon_run_next == 2'd1)) v6_error_next = 1'b1;
    end

    push_val = is_colon ? b_group_accum : group_accum_next;
    if (push_req) begin
      if (b_groups_done >= GROUPS_FULL) begin
        v6_error_next = 1'b1;
      end else begin
        groups_done_next = b_groups_done + 4'd1;
        wr_head          = !gap_seen_next;
        wr_tail          = gap_seen_next;
      end
    end

    chars_seen_next = (b_chars_seen == 2'd2) ? b_chars_seen : b_chars_seen + 2'd1;
  end

  // Dotted quad tracking for one character
  always_comb begin
    octet_index_next     = b_octet_index;
    octet_has_digit_next = b_octet_has_digit;
    v4_possible_next     = b_v4_possible;
    for (int k = 0; k < NUM_OCTETS; k++) begin
      octet_prod[k] = {1'b0, b_octet_values[k], 3'b000} +
                      {3'b000, b_octet_values[k], 1'b0} +
                      {9'd0, chars.char_code[3:0]};
      octet_values_next[k] = b_octet_values[k];
    end
    if (is_dot) begin
      if (!b_octet_has_digit || (b_octet_index >= OCTET_LAST)) begin
        v4_possible_next = 1'b0;
        octet_index_next = OCTET_PAST;
      end else begin
        octet_index_next = b_octet_index + 3'd1;
      end
      octet_has_digit_next = 1'b0;
    end else if (is_dec) begin
      for (int k = 0; k < NUM_OCTETS; k++) begin
        if (b_octet_index == 3'(k)) begin
          octet_values_next[k] = (octet_prod[k] > 13'(OCTET_SAT)) ? OCTET_SAT
                                                                  : octet_prod[k][8:0];
        end
      end
      octet_has_digit_next = 1'b1;
    end else begin
      v4_possible_next = 1'b0;
    end
  end

  // Advance control state on each accepted word, clear after hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      groups_done       <= '0;
      gap_position      <= '0;
      gap_seen          <= 1'b0;
      colon_run         <= '0;
      digit_count       <= '0;
      group_accum       <= '0;
      chars_seen        <= '0;
      starts_with_colon <= 1'b0;
      v6_error          <= 1'b0;
      octet_index       <= '0;
      octet_has_digit   <= 1'b0;
      v4_possible       <= 1'b1;
      text_done         <= 1'b0;
      for (int k = 0; k < NUM_OCTETS; k++) octet_values[k] <= '0;
    end else if (in_acc) begin
      groups_done       <= groups_done_next;
      gap_position      <= gap_position_next;
      gap_seen          <= gap_seen_next;
      colon_run         <= colon_run_next;
      digit_count       <= digit_count_next;
      group_accum       <= group_accum_next;
      chars_seen        <= chars_seen_next;
      starts_with_colon <= starts_with_colon_next;
      v6_error          <= v6_error_next;
      octet_index       <= octet_index_next;
      octet_has_digit   <= octet_has_digit_next;
      v4_possible       <= v4_possible_next;
      text_done         <= chars.is_last;
      for (int k = 0; k < NUM_OCTETS; k++) octet_values[k] <= octet_values_next[k];
    end else if (done_go) begin
      groups_done       <= '0;
      gap_position      <= '0;
      gap_seen          <= 1'b0;
      colon_run         <= '0;
      digit_count       <= '0;
      group_accum       <= '0;
      chars_seen        <= '0;
      starts_with_colon <= 1'b0;
      v6_error          <= 1'b0;
      octet_index       <= '0;
      octet_has_digit   <= 1'b0;
      v4_possible       <= 1'b1;
      text_done         <= 1'b0;
      for (int k = 0; k < NUM_OCTETS; k++) octet_values[k] <= '0;
    end
  end

  // Store groups: before the gap by position, after the gap right-aligned
  always_ff @(posedge clk) begin
    if (in_acc && wr_head) begin
      head[b_groups_done[GROUP_IDX_W-1:0]] <= push_val;
    end
    if (in_acc && wr_tail) begin
      for (int k = 0; k < NUM_GROUPS - 1; k++) tail[k] <= tail[k+1];
      tail[NUM_GROUPS-1] <= push_val;
    end
  end

  // Assemble the finished address
  always_comb begin
    v4_take = v4_possible && octet_has_digit && (octet_index == OCTET_LAST);
    v4_ok   = 1'b1;
    for (int k = 0; k < NUM_OCTETS; k++) begin
      if (octet_values[k][8]) v4_ok = 1'b0;
    end
    v6_ok = !v6_error && (gap_seen ? (groups_done < GROUPS_FULL)
                                   : (groups_done == GROUPS_FULL));
    res_valid = v4_take ? v4_ok : v6_ok;
    for (int i = 0; i < NUM_GROUPS; i++) begin
      res_group[i] = '0;
      if (!res_valid) begin
        res_group[i] = '0;
      end else if (v4_take) begin
        if (i == NUM_GROUPS - 3) res_group[i] = MAPPED_MARK;
        if (i == NUM_GROUPS - 2) res_group[i] = {octet_values[0][7:0], octet_values[1][7:0]};
        if (i == NUM_GROUPS - 1) res_group[i] = {octet_values[2][7:0], octet_values[3][7:0]};
      end else if (!gap_seen || ({1'b0, gap_position} > 5'(i))) begin
        res_group[i] = head[i];
      end else if (({1'b0, groups_done} + 5'(i)) >=
                   (5'(NUM_GROUPS) + {1'b0, gap_position})) begin
        res_group[i] = tail[i];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      addr.valid <= 1'b0;
    end else if (done_go) begin
      addr.valid <= 1'b1;
    end else if (addr.ready) begin
      addr.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      addr.addr_valid <= res_valid;
      addr.from_ipv4  <= res_valid && v4_take;
      addr.group_0    <= res_group[0];
      addr.group_1    <= res_group[1];
      addr.group_2    <= res_group[2];
      addr.group_3    <= res_group[3];
      addr.group_4    <= res_group[4];
      addr.group_5    <= res_group[5];
      addr.group_6    <= res_group[6];
      addr.group_7    <= res_group[7];
    end
  end

  // Checks
  `IPV6P_ASSERT_IMP(a_invalid_zero, clk, rst, addr.valid && !addr.addr_valid, !addr.from_ipv4 && (addr.group_0 == 16'd0) && (addr.group_3 == 16'd0) && (addr.group_7 == 16'd0), "invalid address word carries data")
  `IPV6P_ASSERT_IMP(a_mapped_form, clk, rst, addr.valid && addr.from_ipv4, addr.addr_valid && (addr.group_5 == MAPPED_MARK) && (addr.group_0 == 16'd0), "mapped address malformed")
  `IPV6P_ASSERT_NXT(a_last_closes, clk, rst, chars.valid && chars.ready && chars.is_last, text_done, "last character did not close the text")
  `IPV6P_ASSERT_IMP(a_group_bound, clk, rst, 1'b1, groups_done <= GROUPS_FULL, "group count overflow")

endmodule

### verif/ipv6_parse_checker.sv
// ----------------------------------------------------------------------------
// IPv6 text parser checker
// Watches the character and address channels. Each accepted character
// updates a local model of the parse; a character flagged last yields the
// expected address word. Each accepted address word is compared field by
// field with the oldest expected word.
// ----------------------------------------------------------------------------
module ipv6_parse_checker import ipv6p_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  ipv6p_char_if  chars,
  ipv6p_addr_if  addr,
  output int     errors,
  output int     outstanding,
  output int     legal_addrs,
  output int     mapped_addrs
);

  localparam octet_t OCTET_TOP = 9'd255;

  typedef struct packed {
    logic                        addr_valid;
    logic                        from_ipv4;
    group_t [NUM_GROUPS-1:0]     grp;
  } addr_word_t;

  addr_word_t expected_addrs[$];
  int err_cnt  = 0;
  int good_cnt = 0;
  int quad_cnt = 0;

  // Parse state of the text in flight
  group_t     grp_store [NUM_GROUPS];
  logic [3:0] grp_count;
  logic [3:0] gap_at;
  logic       gap_open;
  logic [1:0] colons;
  logic [2:0] digits;
  group_t     accum;
  logic [1:0] chars_in;
  logic       lead_colon;
  logic       v6_bad;
  octet_t     octets [NUM_OCTETS];
  logic [2:0] oct_idx;
  logic       oct_digit;
  logic       v4_ok;

  assign errors       = err_cnt;
  assign legal_addrs  = good_cnt;
  assign mapped_addrs = quad_cnt;

  function automatic int hex_nibble(char_t c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
    if (c >= CHAR_LC_A && c <= CHAR_LC_F) return int'(c - CHAR_LC_A) + 10;
    if (c >= CHAR_UC_A && c <= CHAR_UC_F) return int'(c - CHAR_UC_A) + 10;
    return -1;
  endfunction

  task automatic restart_text();
    for (int i = 0; i < NUM_GROUPS; i++) grp_store[i] = '0;
    for (int i = 0; i < NUM_OCTETS; i++) octets[i] = '0;
    grp_count  = '0;
    gap_at     = '0;
    gap_open   = 1'b0;
    colons     = '0;
    digits     = '0;
    accum      = '0;
    chars_in   = '0;
    lead_colon = 1'b0;
    v6_bad     = 1'b0;
    oct_idx    = '0;
    oct_digit  = 1'b0;
    v4_ok      = 1'b1;
  endtask

  // Close the open hex group; a ninth group spoils the text
  task automatic close_group();
    if (grp_count >= GROUPS_FULL) begin
      v6_bad = 1'b1;
    end else begin
      grp_store[grp_count[2:0]] = accum;
      grp_count++;
    end
  endtask

  // Advance the parse by one character; on the last one queue the address
  task automatic parse_char(input char_t c, input logic last);
    int         nib;
    int         v;
    int         zeros;
    addr_word_t w;
    nib = hex_nibble(c);

    // IPv6 side
    if (chars_in == 0 && c == CHAR_COLON) lead_colon = 1'b1;
    if (chars_in == 1 && lead_colon && c != CHAR_COLON) v6_bad = 1'b1;
    if (c == CHAR_COLON) begin
      if (colons >= 2) begin
        v6_bad = 1'b1;
        colons = 2'd3;
      end else begin
        colons++;
        if (colons == 2) begin
          if (gap_open) v6_bad = 1'b1;
          gap_open = 1'b1;
          gap_at   = grp_count;
        end else if (digits > 0) begin
          close_group();
        end
      end
      digits = '0;
      accum  = '0;
    end else if (nib >= 0) begin
      colons = '0;
      if (digits >= MAX_DIGITS) begin
        v6_bad = 1'b1;
        digits = OVER_DIGITS;
      end else begin
        digits++;
      end
      accum = {accum[11:0], nib[3:0]};
    end else begin
      v6_bad = 1'b1;
    end

    // Dotted quad side
    if (c == CHAR_DOT) begin
      if (!oct_digit || oct_idx >= OCTET_LAST) begin
        v4_ok   = 1'b0;
        oct_idx = OCTET_PAST;
      end else begin
        oct_idx++;
      end
      oct_digit = 1'b0;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      if (oct_idx < OCTET_PAST) begin
        v = int'(octets[oct_idx]) * 10 + int'(c - CHAR_ZERO);
        octets[oct_idx] = (v > int'(OCTET_SAT)) ? OCTET_SAT : octet_t'(v);
      end
      oct_digit = 1'b1;
    end else begin
      v4_ok = 1'b0;
    end

    if (chars_in < 2) chars_in++;
    if (!last) return;

    // Build the address word
    w = '0;
    if (v4_ok && oct_digit && oct_idx == OCTET_LAST) begin
      if (octets[0] <= OCTET_TOP && octets[1] <= OCTET_TOP &&
          octets[2] <= OCTET_TOP && octets[3] <= OCTET_TOP) begin
        w.addr_valid = 1'b1;
        w.from_ipv4  = 1'b1;
        w.grp[5]     = MAPPED_MARK;
        w.grp[6]     = {octets[0][7:0], octets[1][7:0]};
        w.grp[7]     = {octets[2][7:0], octets[3][7:0]};
      end
    end else begin
      if (digits > 0) close_group();
      if (c == CHAR_COLON && colons == 1) v6_bad = 1'b1;
      if (!v6_bad && (gap_open ? grp_count <= NUM_GROUPS - 1 : grp_count == GROUPS_FULL)) begin
        zeros = NUM_GROUPS - int'(grp_count);
        w.addr_valid = 1'b1;
        for (int i = 0; i < NUM_GROUPS; i++) begin
          if (i < gap_at)              w.grp[i] = grp_store[i];
          else if (i < gap_at + zeros) w.grp[i] = '0;
          else                         w.grp[i] = grp_store[i - zeros];
        end
      end
    end
    if (w.addr_valid) good_cnt++;
    if (w.from_ipv4) quad_cnt++;
    expected_addrs.insert(expected_addrs.size(), w);
    restart_text();
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  // Compare the address word first, then take the character of this edge
  always @(posedge clk) begin
    addr_word_t want;
    addr_word_t got;
    if (rst) begin
      restart_text();
      expected_addrs.delete();
    end else begin
      if (addr.valid && addr.ready) begin
        got.addr_valid = addr.addr_valid;
        got.from_ipv4  = addr.from_ipv4;
        got.grp[0]     = addr.group_0;
        got.grp[1]     = addr.group_1;
        got.grp[2]     = addr.group_2;
        got.grp[3]     = addr.group_3;
        got.grp[4]     = addr.group_4;
        got.grp[5]     = addr.group_5;
        got.grp[6]     = addr.group_6;
        got.grp[7]     = addr.group_7;
        if (expected_addrs.size() == 0) begin
          $error("address word with no text pending");
          err_cnt++;
        end else begin
          want = expected_addrs.pop_front();
          check_field("addr_valid", 16'(want.addr_valid), 16'(got.addr_valid));
          check_field("from_ipv4", 16'(want.from_ipv4), 16'(got.from_ipv4));
          for (int i = 0; i < NUM_GROUPS; i++)
            check_field($sformatf("group_%0d", i), want.grp[i], got.grp[i]);
        end
      end
      if (chars.valid && chars.ready) parse_char(chars.char_code, chars.is_last);
    end
    outstanding <= expected_addrs.size();
  end

endmodule

### verif/tb_ipv6_text_address_parser_core.sv
// ----------------------------------------------------------------------------
// IPv6 text parser testbench
// Feeds address texts one character per word: a directed set of edge cases,
// then random IPv6 and dotted-quad texts (some octets out of range), garbled copies and
// byte noise, with random idling on both channels. The checker predicts and
// compares every address word.
// ----------------------------------------------------------------------------
module tb_ipv6_text_address_parser_core;
  import ipv6p_pkg::*;

  localparam int RANDOM_CHARS = 1600;
  localparam int CALM_FROM    = 1350;
  localparam int HOLD_AT      = 400;
  localparam int PAUSE_AT     = 1000;
  localparam int LONG_HOLD    = 300;
  localparam int LIMIT        = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic calm = 1'b0;
  logic hold_req = 1'b0;

  int error_count;
  int pending_addrs;
  int legal_addrs;
  int mapped_addrs;
  int text_count = 0;
  int char_count = 0;
  int cycle_count = 0;

  char_t text[$];
  string symbols = ":.0123456789abcdefABCDEFgx";
  char_t extreme_bytes [4] = '{8'h00, 8'h7f, 8'h80, 8'hff};
  string directed_texts [] = '{
    "::", "::1", "1::", "FFFF:ffff:AbCd:0123:4567:89ab:cdef:fFfF",
    "1:2:3:4:5:6:7", "1:2:3:4:5:6:7:8:9", "1::2:3:4:5:6:7:8", "1::2:3:4:5:6:7",
    ":1::", "1::2:", ":", ":::", "1:::2", "1::2::3", "12345::", "1:g::",
    "255.255.255.255", "001.02.3.004", "256.1.1.1", ".1.2.3", "1..2.3",
    "1.2.3", "1.2.3.4.5", "1.2.3.", "1:2:3:4:5:6:1.2.3.4"
  };

  ipv6p_char_if chars_ch ();
  ipv6p_addr_if addr_ch ();

  ipv6_text_address_parser_core dut (
    .clk   (clk),
    .rst   (rst),
    .chars (chars_ch),
    .addr  (addr_ch)
  );

  ipv6_parse_checker parse_chk (
    .clk          (clk),
    .rst          (rst),
    .chars        (chars_ch),
    .addr         (addr_ch),
    .errors       (error_count),
    .outstanding  (pending_addrs),
    .legal_addrs  (legal_addrs),
    .mapped_addrs (mapped_addrs)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // End the run if it stalls
  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Drive ready with random stall bursts and one long hold-off on request
  initial begin : addr_receiver
    int stall_left;
    int stall_pct;
    bit hold_used;
    stall_left = 0;
    stall_pct  = 20;
    hold_used  = 1'b0;
    addr_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_req && !hold_used) begin
        stall_left = LONG_HOLD;
        hold_used  = 1'b1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 9);
      end
      addr_ch.ready <= (stall_left == 0);
    end
  end

  // Add one character at the end of the text queue
  task automatic append_char(input char_t ch);
    text.insert(text.size(), ch);
  endtask

  // Send the text queue one character per word, with random gaps
  task automatic send_text();
    int gap_pct;
    case ($urandom_range(0, 2))
      0: gap_pct = 0;
      1: gap_pct = 10;
      default: gap_pct = 35;
    endcase
    for (int j = 0; j < text.size(); j++) begin
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
        chars_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      chars_ch.valid     <= 1'b1;
      chars_ch.char_code <= text[j];
      chars_ch.is_last   <= (j == text.size() - 1);
      do @(posedge clk); while (chars_ch.ready !== 1'b1);
    end
    text_count++;
    char_count += text.size();
  endtask

  // Hold the sender until every expected address word has come back
  task automatic drain_addrs();
    chars_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_addrs != 0) @(posedge clk);
  endtask

  // Build a random text: IPv6, dotted quad, a garbled copy of either, or noise
  task automatic make_random_text();
    int    kind;
    int    n_grp;
    int    gap;
    int    v;
    int    pos;
    char_t ch;
    text.delete();
    kind = $urandom_range(0, 99);
    if (kind < 90) begin
      if (kind < 45 || (kind >= 65 && kind[0])) begin
        if ($urandom_range(0, 1)) begin
          n_grp = $urandom_range(0, 7);
          gap   = $urandom_range(0, n_grp);
        end else begin
          n_grp = NUM_GROUPS;
          gap   = -1;
        end
        for (int i = 0; i < n_grp; i++) begin
          if (i == gap) begin
            append_char(CHAR_COLON);
            append_char(CHAR_COLON);
          end else if (i > 0) begin
            append_char(CHAR_COLON);
          end
          repeat ($urandom_range(1, 4)) begin
            v = $urandom_range(0, 15);
            if (v < 10) ch = char_t'(CHAR_ZERO + v);
            else ch = char_t'(($urandom_range(0, 1) ? CHAR_LC_A : CHAR_UC_A) + v - 10);
            append_char(ch);
          end
        end
        if (gap == n_grp) begin
          append_char(CHAR_COLON);
          append_char(CHAR_COLON);
        end
      end else begin
        for (int o = 0; o < NUM_OCTETS; o++) begin
          if (o > 0) append_char(CHAR_DOT);
          v = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 999) : $urandom_range(0, 255);
          if ($urandom_range(0, 7) == 0) append_char(CHAR_ZERO);
          if (v >= 100) append_char(char_t'(CHAR_ZERO + v / 100));
          if (v >= 10) append_char(char_t'(CHAR_ZERO + (v / 10) % 10));
          append_char(char_t'(CHAR_ZERO + v % 10));
        end
      end
      // Garble: replace, insert or drop a character
      if (kind >= 65) begin
        repeat ($urandom_range(1, 2)) begin
          pos = $urandom_range(0, text.size() - 1);
          if ($urandom_range(0, 1)) ch = symbols[$urandom_range(0, symbols.len() - 1)];
          else ch = char_t'($urandom_range(0, 255));
          case ($urandom_range(0, 2))
            0: text[pos] = ch;
            1: text.insert(pos, ch);
            default: if (text.size() > 1) text.delete(pos);
          endcase
        end
      end
    end else begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 1)) ch = symbols[$urandom_range(0, symbols.len() - 1)];
        else ch = char_t'($urandom_range(0, 255));
        append_char(ch);
      end
    end
  endtask

  initial begin : stimulus
    int rand_chars;
    bit hold_done;
    bit paused;
    rand_chars = 0;
    hold_done  = 1'b0;
    paused     = 1'b0;
    chars_ch.valid     <= 1'b0;
    chars_ch.char_code <= '0;
    chars_ch.is_last   <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed edge cases
    for (int t = 0; t < directed_texts.size(); t++) begin
      text.delete();
      for (int j = 0; j < directed_texts[t].len(); j++) append_char(directed_texts[t][j]);
      send_text();
    end
    for (int j = 0; j < 4; j++) begin
      text.delete();
      append_char(extreme_bytes[j]);
      send_text();
    end
    drain_addrs();

    // Random texts
    while (rand_chars < RANDOM_CHARS) begin
      make_random_text();
      if (!hold_done && rand_chars >= HOLD_AT) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!paused && rand_chars >= PAUSE_AT) begin
        drain_addrs();
        paused = 1'b1;
      end
      if (rand_chars >= CALM_FROM) calm = 1'b1;
      send_text();
      rand_chars += text.size();
    end

    drain_addrs();
    repeat (4) @(posedge clk);
    $display("Sent %0d texts in %0d characters; %0d parsed as legal addresses, %0d dotted quads.",
             text_count, char_count, legal_addrs, mapped_addrs);
    if (error_count == 0 && pending_addrs == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
